FILE: design/bbo_pkg.sv
package bbo_pkg;

  // Sizing of the box list and of the coordinates.
  localparam int MAX_BOXES   = 12;
  localparam int COORD_WIDTH = 10;
  localparam int IDX_W       = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W       = $clog2(MAX_BOXES + 1);
  localparam int DIM_W       = COORD_WIDTH + 1;
  localparam int PIX_W       = 16;

  // Configuration register widths and reset values.
  localparam int FW_W = 11;
  localparam int FH_W = 11;
  localparam int BC_W = 16;
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = FW_W'(320);
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = FH_W'(240);
  localparam logic [BC_W-1:0]  BORDER_COLOR_RST = BC_W'(16'hFFE0);

  // Configuration port.
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BORDER_COLOR = 2'd2;

  // Item opcodes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PIXEL  = 2'd2;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } box_t;

  // Everything one item carries along the cell chain.
  typedef struct packed {
    logic             is_pixel;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] cnt;
    box_t             box;
    coord_t           col;
    coord_t           row;
    logic [PIX_W-1:0] pix;
    logic             last;
    logic             hit;
  } item_t;

endpackage

FILE: design/bbo_if.sv
// Input item channel.
interface bbo_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [bbo_pkg::COORD_WIDTH-1:0] box_left;
  logic [bbo_pkg::COORD_WIDTH-1:0] box_top;
  logic [bbo_pkg::COORD_WIDTH-1:0] box_right;
  logic [bbo_pkg::COORD_WIDTH-1:0] box_bottom;
  logic [bbo_pkg::PIX_W-1:0]       pixel_in;

  modport source (output valid, opcode, box_left, box_top, box_right, box_bottom,
                  pixel_in, input ready);
  modport sink   (input valid, opcode, box_left, box_top, box_right, box_bottom,
                  pixel_in, output ready);
endinterface

// Result item channel.
interface bbo_out_if;
  logic                      valid;
  logic                      ready;
  logic [bbo_pkg::PIX_W-1:0] pixel_out;
  logic                      on_outline;
  logic                      frame_end;

  modport source (output valid, pixel_out, on_outline, frame_end, input ready);
  modport sink   (input valid, pixel_out, on_outline, frame_end, output ready);
endinterface

FILE: design/box_outline_overlay.sv
// Box outline overlay for an RGB565 pixel stream.
// Items arrive on in_ch: opcode 0 clears the box list, 1 appends a box
// (ignored once the list holds MAX_BOXES boxes), 2 carries one pixel.
// Each pixel item gives one result on out_ch: the pixel or the border
// color, an on-outline flag and a frame-end flag; other items give none.
// Column and row counters advance with every pixel item.
// Items pass through a chain of MAX_BOXES cells, one box per cell, one cell
// per cycle; the last cell's stage register is the output register.
// Throughput is one item per cycle. When out_ch stalls with a result
// waiting, the whole chain holds and in_ch.ready drops until it is taken.
// Configuration (frame width, frame height, border color) is written over the APB port at byte
// addresses 0, 4 and 8; the user must write it only while idle, the block does not enforce this.
// Reset empties the chain, the box list and the counters, and loads the
// registers with 320, 240 and yellow. No clearing pass is needed.
module box_outline_overlay (
  input  logic                        clk,
  input  logic                        rst_n,
  bbo_in_if.sink                      in_ch,
  bbo_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bbo_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [bbo_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [bbo_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int N = bbo_pkg::MAX_BOXES;

  logic [bbo_pkg::FW_W-1:0] frame_width_r;
  logic [bbo_pkg::FH_W-1:0] frame_height_r;
  logic [bbo_pkg::BC_W-1:0] border_color_r;

  logic [bbo_pkg::CNT_W-1:0] box_cnt_r, box_cnt_nxt;
  bbo_pkg::coord_t           col_r, col_nxt, row_r, row_nxt;

  logic adv, accept, cfg_wr;
  logic [1:0] reg_idx;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bbo_pkg::FRAME_WIDTH_RST;
      frame_height_r <= bbo_pkg::FRAME_HEIGHT_RST;
      border_color_r <= bbo_pkg::BORDER_COLOR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        bbo_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[bbo_pkg::FW_W-1:0];
        bbo_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[bbo_pkg::FH_W-1:0];
        bbo_pkg::REG_BORDER_COLOR: border_color_r <= cfg_pwdata[bbo_pkg::BC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bbo_pkg::REG_FRAME_WIDTH:
        cfg_prdata = bbo_pkg::APB_DW'(frame_width_r);
      bbo_pkg::REG_FRAME_HEIGHT:
        cfg_prdata = bbo_pkg::APB_DW'(frame_height_r);
      bbo_pkg::REG_BORDER_COLOR:
        cfg_prdata = bbo_pkg::APB_DW'(border_color_r);
      default:
        cfg_prdata = '0;
    endcase
  end

  // Clamp the frame size to 1 .. 2^COORD_WIDTH and find the last column and row.
  logic [bbo_pkg::DIM_W-1:0] w_cl, h_cl, w_m1, h_m1;
  logic [bbo_pkg::DIM_W-1:0] fw_ext, fh_ext;
  logic col_wrap, row_wrap;

  localparam logic [bbo_pkg::DIM_W-1:0] DIM_MAX = bbo_pkg::DIM_W'(1 << bbo_pkg::COORD_WIDTH);

  always_comb begin
    fw_ext = bbo_pkg::DIM_W'(frame_width_r);
    fh_ext = bbo_pkg::DIM_W'(frame_height_r);
    if (frame_width_r == '0) begin
      w_cl = bbo_pkg::DIM_W'(1);
    end else if (fw_ext > DIM_MAX) begin
      w_cl = DIM_MAX;
    end else begin
      w_cl = fw_ext;
    end
    if (frame_height_r == '0) begin
      h_cl = bbo_pkg::DIM_W'(1);
    end else if (fh_ext > DIM_MAX) begin
      h_cl = DIM_MAX;
    end else begin
      h_cl = fh_ext;
    end
    w_m1     = w_cl - 1'b1;
    h_m1     = h_cl - 1'b1;
    col_wrap = {1'b0, col_r} >= w_m1;
    row_wrap = {1'b0, row_r} >= h_m1;
  end

  // Entry: counters, box count and the item that goes into the first cell.
  logic           is_pix, is_app, is_clr;
  logic           entry_valid;
  bbo_pkg::item_t entry;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    is_pix = (in_ch.opcode == bbo_pkg::OP_PIXEL);
    is_app = (in_ch.opcode == bbo_pkg::OP_APPEND);
    is_clr = (in_ch.opcode == bbo_pkg::OP_CLEAR);

    entry.is_pixel = is_pix;
    entry.wr_en    = is_app && (box_cnt_r < bbo_pkg::CNT_W'(N));
    entry.wr_idx   = box_cnt_r[bbo_pkg::IDX_W-1:0];
    entry.cnt      = box_cnt_r;
    entry.box.x1   = in_ch.box_left;
    entry.box.y1   = in_ch.box_top;
    entry.box.x2   = in_ch.box_right;
    entry.box.y2   = in_ch.box_bottom;
    entry.col      = col_r;
    entry.row      = row_r;
    entry.pix      = in_ch.pixel_in;
    entry.last     = col_wrap && row_wrap;
    entry.hit      = 1'b0;
    entry_valid    = accept && (entry.is_pixel || entry.wr_en);

    box_cnt_nxt = box_cnt_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (accept) begin
      if (is_clr) begin
        box_cnt_nxt = '0;
      end else if (entry.wr_en) begin
        box_cnt_nxt = box_cnt_r + 1'b1;
      end
      if (is_pix) begin
        if (col_wrap) begin
          col_nxt = '0;
          row_nxt = row_wrap ? '0 : row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_cnt_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      box_cnt_r <= box_cnt_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

  // Cell chain; the whole chain moves unless a result waits at the end.
  logic           valid_c [N+1];
  bbo_pkg::item_t item_c  [N+1];

  assign valid_c[0] = entry_valid;
  assign item_c[0]  = entry;

  for (genvar k = 0; k < N; k++) begin : g_cell
    bbo_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (bbo_pkg::IDX_W'(k)),
      .valid_i  (valid_c[k]),
      .item_i   (item_c[k]),
      .valid_o  (valid_c[k+1]),
      .item_o   (item_c[k+1])
    );
  end

  // Output: only pixel items leave the chain as results.
  assign out_ch.valid      = valid_c[N] && item_c[N].is_pixel;
  assign out_ch.on_outline = item_c[N].hit;
  assign out_ch.frame_end  = item_c[N].last;
  assign out_ch.pixel_out  = item_c[N].hit ? border_color_r : item_c[N].pix;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

endmodule

FILE: design/bbo_cell.sv
module bbo_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [bbo_pkg::IDX_W-1:0] cell_idx,
  input  logic                      valid_i,
  input  bbo_pkg::item_t            item_i,
  output logic                      valid_o,
  output bbo_pkg::item_t            item_o
);

  bbo_pkg::box_t  box_r;
  logic           valid_r;
  bbo_pkg::item_t item_r;
  bbo_pkg::item_t item_nxt;

  logic [bbo_pkg::DIM_W-1:0] col, row, x1, y1, x2, y2;
  logic in_rows, h_band, v_rows, v_cols, on_box, live;

  // Outline test of the held box against the passing pixel position.
  always_comb begin
    col = {1'b0, item_i.col};
    row = {1'b0, item_i.row};
    x1  = {1'b0, box_r.x1};
    y1  = {1'b0, box_r.y1};
    x2  = {1'b0, box_r.x2};
    y2  = {1'b0, box_r.y2};
    in_rows = (row == y1) || (row == y1 + 1'b1) || (row == y2) || (row == y2 + 1'b1);
    h_band  = in_rows && (col >= x1) && (col < x2);
    v_rows  = (row > y1) && (row < y2);
    v_cols  = (col == x1) || (col == x1 + 1'b1) ||
              (col + 2'd2 == x2) || (col + 1'b1 == x2);
    on_box  = h_band || (v_rows && v_cols);
    // Only boxes that were in the list when the pixel entered take part.
    live    = bbo_pkg::CNT_W'(cell_idx) < item_i.cnt;
    item_nxt     = item_i;
    item_nxt.hit = item_i.hit | (item_i.is_pixel & live & on_box);
  end

  // Box held by this cell; an append addressed here loads it.
  always_ff @(posedge clk) begin
    if (adv && valid_i && item_i.wr_en && (item_i.wr_idx == cell_idx)) begin
      box_r <= item_i.box;
    end
  end

  // Stage register handing the item to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule
